// ----- rtl/serial_frame_sync_classifier_macros.svh -----
// ----------------------------------------------------------------------------
// serial frame sync classifier assertion macros
// shared property forms for the block's checks
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_SYNC_CLASSIFIER_MACROS_SVH
`define SERIAL_FRAME_SYNC_CLASSIFIER_MACROS_SVH

// same-cycle implication
`define SFSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SFSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sfsc_pkg.sv -----
// ----------------------------------------------------------------------------
// sfsc_pkg
// header bytes, guard byte and the fixed frame table of the classifier
// ----------------------------------------------------------------------------
package sfsc_pkg;

  localparam logic [7:0] HDR0        = 8'h55;
  localparam logic [7:0] HDR1        = 8'hAA;
  localparam logic [7:0] REPLY_GUARD = 8'h55;
  localparam int unsigned GUARD_SLOT = 6;

  localparam int unsigned NUM_FRAMES  = 8;
  localparam int unsigned CMP_BYTES   = 8;
  // the info query frame never rewrites the guard slot
  localparam int unsigned INFO_FRAME  = 1;

  typedef enum logic {
    REQ_BYTE     = 1'b0,
    REQ_CLASSIFY = 1'b1
  } req_t;

  localparam logic [7:0] FRAMES [NUM_FRAMES][CMP_BYTES] = '{
    '{8'h55, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00},
    '{8'h55, 8'hAA, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h55, 8'hAA, 8'h00, 8'h02, 8'h00, 8'h00, 8'h01, 8'h00},
    '{8'h55, 8'hAA, 8'h00, 8'h03, 8'h00, 8'h01, 8'h00, 8'h03},
    '{8'h55, 8'hAA, 8'h00, 8'h03, 8'h00, 8'h01, 8'h01, 8'h04},
    '{8'h55, 8'hAA, 8'h00, 8'h03, 8'h00, 8'h01, 8'h02, 8'h05},
    '{8'h55, 8'hAA, 8'h00, 8'h03, 8'h00, 8'h01, 8'h03, 8'h06},
    '{8'h55, 8'hAA, 8'h00, 8'h03, 8'h00, 8'h01, 8'h04, 8'h07}
  };

  // leading bytes compared per frame
  localparam logic [3:0] FRAME_LEN [NUM_FRAMES] = '{
    4'd7, 4'd7, 4'd7, 4'd8, 4'd8, 4'd8, 4'd8, 4'd8
  };

endpackage

// ----- rtl/serial_frame_sync_classifier.sv -----
// ----------------------------------------------------------------------------
// serial_frame_sync_classifier
// frame sync on received bytes and fixed frame classification
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with req_type and rx_byte. req_type 0
// delivers a received byte, req_type 1 asks to classify the held frame.
// Output channel: out_valid / out_stall with status and bytes_held, one
// result for every input transfer, showing the state after that item.
// The state registers double as the result register, and out_valid rises
// the cycle after the input transfer.
// Throughput is one item per cycle; the only limit is the single result
// register, so in_stall follows out_stall while a result is waiting.
// Only buffer bytes 0 to 7 are ever compared, so only those are kept;
// bytes stored further into the frame only advance the write index.
// Reset (rst, synchronous) clears the byte window, write index, buffer and
// status, and empties the result register. While the receiver stalls the
// result holds steady and no new input is taken.
// ----------------------------------------------------------------------------
`include "serial_frame_sync_classifier_macros.svh"

module serial_frame_sync_classifier #(
  parameter int unsigned FRAME_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       req_type,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] status,
  output logic [4:0] bytes_held
);

  localparam int unsigned IDX_W = $clog2(FRAME_BYTES + 1);

  logic             in_fire;
  logic [7:0]       last_byte;
  logic [IDX_W-1:0] write_index;
  logic [IDX_W-1:0] write_index_next;
  logic [7:0]       frame_store [sfsc_pkg::CMP_BYTES];
  logic [3:0]       status_code;
  logic [3:0]       status_code_next;
  logic             header_seen;
  logic             store_byte;
  logic             store_slot_ok;
  logic             guard_write;
  logic [sfsc_pkg::NUM_FRAMES-1:0] frame_hit;
  logic [31:0]      index_ext;

  assign in_stall = out_valid & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  // byte path
  assign header_seen   = (last_byte == sfsc_pkg::HDR0) && (rx_byte == sfsc_pkg::HDR1);
  assign store_byte    = !header_seen && (write_index >= IDX_W'(2))
                         && (write_index < IDX_W'(FRAME_BYTES));
  assign store_slot_ok = (write_index < IDX_W'(sfsc_pkg::CMP_BYTES));

  always_comb begin
    if (header_seen) begin
      write_index_next = IDX_W'(2);
    end else if (store_byte) begin
      write_index_next = write_index + IDX_W'(1);
    end else begin
      write_index_next = '0;
    end
  end

  // frames differ in byte 3 or byte 6, so at most one can hit
  always_comb begin
    for (int k = 0; k < sfsc_pkg::NUM_FRAMES; k++) begin
      frame_hit[k] = 1'b1;
      for (int i = 0; i < sfsc_pkg::CMP_BYTES; i++) begin
        if ((4'(i) < sfsc_pkg::FRAME_LEN[k])
            && (frame_store[i] != sfsc_pkg::FRAMES[k][i])) begin
          frame_hit[k] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    status_code_next = status_code;
    guard_write      = 1'b0;
    for (int k = 0; k < sfsc_pkg::NUM_FRAMES; k++) begin
      if (frame_hit[k]) begin
        status_code_next = 4'(k + 1);
        if (k != sfsc_pkg::INFO_FRAME) begin
          guard_write = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_byte   <= '0;
      write_index <= '0;
      status_code <= '0;
      for (int i = 0; i < sfsc_pkg::CMP_BYTES; i++) begin
        frame_store[i] <= '0;
      end
    end else if (in_fire) begin
      unique case (sfsc_pkg::req_t'(req_type))
        sfsc_pkg::REQ_BYTE: begin
          last_byte   <= rx_byte;
          write_index <= write_index_next;
          if (header_seen) begin
            frame_store[0] <= sfsc_pkg::HDR0;
            frame_store[1] <= sfsc_pkg::HDR1;
          end else if (store_byte && store_slot_ok) begin
            frame_store[write_index[2:0]] <= rx_byte;
          end
        end
        sfsc_pkg::REQ_CLASSIFY: begin
          status_code <= status_code_next;
          if (guard_write) begin
            frame_store[sfsc_pkg::GUARD_SLOT] <= sfsc_pkg::REPLY_GUARD;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign index_ext  = 32'(write_index);
  assign status     = status_code;
  assign bytes_held = index_ext[4:0];

  `SFSC_ASSERT_NOW(a_status_range, 1'b1, status_code <= 4'd8,
    "status code out of range")
  `SFSC_ASSERT_NOW(a_index_range, 1'b1, write_index <= IDX_W'(FRAME_BYTES),
    "write index beyond frame length")
  `SFSC_ASSERT_NEXT(a_classify_keeps_index, in_fire && req_type,
    $stable(write_index), "classify moved the write index")
  `SFSC_ASSERT_NEXT(a_header_restarts,
    in_fire && !req_type && rx_byte == sfsc_pkg::HDR1 && last_byte == sfsc_pkg::HDR0,
    write_index == IDX_W'(2), "header transfer did not restart the frame")

endmodule

// ----- tb/serial_frame_sync_classifier_sb.sv -----
// ----------------------------------------------------------------------------
// serial_frame_sync_classifier_sb
// watches both channels of the frame sync classifier, tracks the byte window,
// frame buffer, write index and sticky status on its own, and compares every
// output transfer with the oldest predicted status word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_frame_sync_classifier_sb #(
  parameter int unsigned FRAME_BYTES = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       req_type,
  input  logic [7:0] rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [3:0] status,
  input  logic [4:0] bytes_held,
  output int         mismatches,
  output int         awaited
);

  typedef struct packed {
    logic [3:0] status;
    logic [4:0] held;
  } status_word_t;

  // frames the classifier recognizes, codes 1 to 8 in order
  localparam logic [7:0] KNOWN_FRAMES [8][8] = '{
    '{8'h55, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00},
    '{8'h55, 8'hAA, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h55, 8'hAA, 8'h00, 8'h02, 8'h00, 8'h00, 8'h01, 8'h00},
    '{8'h55, 8'hAA, 8'h00, 8'h03, 8'h00, 8'h01, 8'h00, 8'h03},
    '{8'h55, 8'hAA, 8'h00, 8'h03, 8'h00, 8'h01, 8'h01, 8'h04},
    '{8'h55, 8'hAA, 8'h00, 8'h03, 8'h00, 8'h01, 8'h02, 8'h05},
    '{8'h55, 8'hAA, 8'h00, 8'h03, 8'h00, 8'h01, 8'h03, 8'h06},
    '{8'h55, 8'hAA, 8'h00, 8'h03, 8'h00, 8'h01, 8'h04, 8'h07}
  };
  localparam int KNOWN_LEN [8] = '{7, 7, 7, 8, 8, 8, 8, 8};

  logic [7:0]   win_new;
  logic [7:0]   win_old;
  int unsigned  wr_idx;
  logic [7:0]   frame_buf [FRAME_BYTES];
  logic [3:0]   sticky_code;
  status_word_t status_due [$];

  initial mismatches = 0;

  task automatic report(input string msg);
    $display("[%0t] %s", $time, msg);
    mismatches++;
  endtask

  task automatic track_request(input logic req, input logic [7:0] b);
    bit hit;
    if (sfsc_pkg::req_t'(req) == sfsc_pkg::REQ_CLASSIFY) begin
      // later frames see the guard byte written by an earlier match
      for (int k = 0; k < 8; k++) begin
        hit = 1'b1;
        for (int i = 0; i < KNOWN_LEN[k]; i++)
          if (frame_buf[i] != KNOWN_FRAMES[k][i]) hit = 1'b0;
        if (hit) begin
          sticky_code = 4'(k + 1);
          if (k != sfsc_pkg::INFO_FRAME)
            frame_buf[sfsc_pkg::GUARD_SLOT] = sfsc_pkg::REPLY_GUARD;
        end
      end
    end else begin
      win_old = win_new;
      win_new = b;
      if (win_old == sfsc_pkg::HDR0 && win_new == sfsc_pkg::HDR1) begin
        frame_buf[0] = win_old;
        frame_buf[1] = win_new;
        wr_idx = 2;
      end else if (wr_idx >= 2 && wr_idx < FRAME_BYTES) begin
        frame_buf[wr_idx] = b;
        wr_idx++;
      end else begin
        wr_idx = 0;
      end
    end
    status_due.push_back('{status: sticky_code, held: wr_idx[4:0]});
  endtask

  always @(posedge clk) begin
    status_word_t want;
    if (rst) begin
      win_new = '0;
      win_old = '0;
      wr_idx = 0;
      sticky_code = '0;
      for (int i = 0; i < FRAME_BYTES; i++) frame_buf[i] = '0;
      status_due.delete();
    end else begin
      // the result leaving now belongs to an earlier transfer
      if (out_valid && !out_stall) begin
        if (status_due.size() == 0) begin
          report($sformatf("result transfer with nothing pending: status %0d bytes_held %0d",
                           status, bytes_held));
        end else begin
          want = status_due.pop_front();
          if (status !== want.status)
            report($sformatf("status: expected %0d, got %0d", want.status, status));
          if (bytes_held !== want.held)
            report($sformatf("bytes_held: expected %0d, got %0d", want.held, bytes_held));
        end
      end
      if (in_valid && !in_stall) track_request(req_type, rx_byte);
    end
    awaited = status_due.size();
  end

endmodule

// ----- tb/serial_frame_sync_classifier_tb.sv -----
// ----------------------------------------------------------------------------
// serial_frame_sync_classifier_tb
// drives received bytes and classify requests into the classifier: a short
// directed run over fixed frames 0 and 1, then random frames, broken frames and
// noise under bursty input and patterned output stalls; the scoreboard
// beside the block does the checking and this module gives the verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module serial_frame_sync_classifier_tb;

  localparam int unsigned FRAME_BYTES  = 16;
  localparam int          RANDOM_ITEMS = 550;
  localparam int          IDLE_LIMIT   = 2000;
  localparam int          TAIL_CYCLES  = 4;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_COMB,
    STALL_HEAVY
  } stall_mode_t;

  logic       clk;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       req_type  = sfsc_pkg::REQ_BYTE;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_stall = 1'b0;
  wire        in_stall;
  wire        out_valid;
  wire  [3:0] status;
  wire  [4:0] bytes_held;

  int          mismatches;
  int          awaited;
  int          items_sent = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;
  int          stall_phase = 0;
  stall_mode_t stall_mode = STALL_NONE;

  serial_frame_sync_classifier #(.FRAME_BYTES(FRAME_BYTES)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .bytes_held(bytes_held)
  );

  serial_frame_sync_classifier_sb #(.FRAME_BYTES(FRAME_BYTES)) scoreboard_u (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .bytes_held(bytes_held),
    .mismatches(mismatches),
    .awaited   (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stall pattern, switching between four styles at random
  always @(negedge clk) begin
    if (stall_phase % 48 == 0) stall_mode = stall_mode_t'($urandom_range(0, 3));
    stall_phase++;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 9) < 3);
      STALL_COMB:  out_stall <= (stall_phase % 4 == 0);
      default:     out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_item(input sfsc_pkg::req_t req, input logic [7:0] b);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    req_type <= req;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    burst_left--;
    items_sent++;
  endtask

  // header, body bytes 2 to 7 of fixed frame k (random past its length), optional bit flip, trailing bytes
  task automatic send_frame(input int k, input int flip_at, input int tail);
    logic [7:0] b;
    send_item(sfsc_pkg::REQ_BYTE, sfsc_pkg::HDR0);
    send_item(sfsc_pkg::REQ_BYTE, sfsc_pkg::HDR1);
    for (int i = 2; i < 8; i++) begin
      b = (i < sfsc_pkg::FRAME_LEN[k]) ? sfsc_pkg::FRAMES[k][i] : 8'($urandom);
      if (i == flip_at) b ^= 8'(1 << $urandom_range(0, 7));
      send_item(sfsc_pkg::REQ_BYTE, b);
    end
    repeat (tail) send_item(sfsc_pkg::REQ_BYTE, 8'($urandom));
  endtask

  initial begin
    int base;
    int pick;
    int k;
    int cut;
    bit paused;
    paused = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // classify on an empty buffer, then bytes dropped at index 0
    send_item(sfsc_pkg::REQ_CLASSIFY, 8'hFF);
    send_item(sfsc_pkg::REQ_BYTE, 8'hFF);
    send_item(sfsc_pkg::REQ_BYTE, 8'h00);
    // heartbeat matches once, the guard byte stops the repeat
    send_frame(0, -1, 0);
    send_item(sfsc_pkg::REQ_CLASSIFY, 8'h00);
    send_item(sfsc_pkg::REQ_CLASSIFY, 8'hA5);
    // header restarts the frame mid-way; info query keeps matching
    send_frame(1, -1, 0);
    send_item(sfsc_pkg::REQ_CLASSIFY, 8'h5A);
    send_item(sfsc_pkg::REQ_CLASSIFY, 8'hFF);

    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      if (!paused && items_sent - base > RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (awaited != 0) @(negedge clk);
      end
      pick = $urandom_range(0, 9);
      k = $urandom_range(0, sfsc_pkg::NUM_FRAMES - 1);
      if (pick <= 5) begin
        // well-formed frame, sometimes corrupted, sometimes run past a full buffer
        send_frame(k, ($urandom_range(0, 5) == 0) ? $urandom_range(2, 7) : -1,
                   ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(0, 2));
        repeat ($urandom_range(1, 2)) send_item(sfsc_pkg::REQ_CLASSIFY, 8'($urandom));
      end else if (pick <= 7) begin
        // cut-short frame: old bytes past the last slot sent stay in place
        send_item(sfsc_pkg::REQ_BYTE, sfsc_pkg::HDR0);
        send_item(sfsc_pkg::REQ_BYTE, sfsc_pkg::HDR1);
        cut = 2 + $urandom_range(0, 5);
        for (int i = 2; i < cut; i++)
          send_item(sfsc_pkg::REQ_BYTE, sfsc_pkg::FRAMES[k][i]);
        send_item(sfsc_pkg::REQ_CLASSIFY, 8'($urandom));
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 3) == 0)
            send_item(sfsc_pkg::REQ_CLASSIFY, 8'($urandom));
          else if ($urandom_range(0, 3) == 0)
            send_item(sfsc_pkg::REQ_BYTE,
                      $urandom_range(0, 1) ? sfsc_pkg::HDR0 : sfsc_pkg::HDR1);
          else
            send_item(sfsc_pkg::REQ_BYTE, 8'($urandom));
        end
      end else begin
        send_item(sfsc_pkg::REQ_CLASSIFY, 8'($urandom));
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && awaited == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
